### src/utf8_to_utf16_transcoder_core_macros.svh
// Assertion macros shared by the transcoder checker.
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define U8U16_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define U8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
  localparam logic [20:0] SCALAR_MAX       = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST       = 21'h00D800;
  localparam logic [20:0] SURR_LAST        = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE        = 21'h010000;
  localparam logic [20:0] MIN_LEN2         = 21'h000080;
  localparam logic [20:0] MIN_LEN3         = 21'h000800;
  localparam logic [5:0]  HI_SURR_TAG      = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG      = 6'b110111;

  // Sequence lengths held in the decoder.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  localparam int MAX_UNITS = 4;

  // Words produced by one text byte, handed from decoder to output buffer.
  typedef struct packed {
    logic [2:0]                  count;
    logic [MAX_UNITS-1:0][15:0] units;
    logic                        done;
  } burst_t;

endpackage

### src/u8u16_decode.sv
// Sequence decoder: holds the pending sequence and turns one byte into words.
module u8u16_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance_i,
  input  logic [7:0]        byte_i,
  input  logic              fin_i,
  output u8u16_pkg::burst_t burst_o
);
  import u8u16_pkg::*;

  logic [14:0] ps_r,   ps_nxt;
  logic [2:0]  len_r,  len_nxt;
  logic [1:0]  held_r, held_nxt;

  logic        bb_emit;
  logic [15:0] bb_unit;
  logic [2:0]  bb_len;
  logic [14:0] bb_bits;
  logic [20:0] scal;
  logic [20:0] supp;
  logic [2:0]  held_inc;
  logic        scal_bad;
  logic [2:0]  nrep;
  logic [1:0]  ntail;
  logic [15:0] tail0;
  logic [15:0] tail1;

  // Decode a byte as if nothing were pending.
  always_comb begin
    bb_emit = 1'b1;
    bb_unit = REPLACEMENT_UNIT;
    bb_len  = LEN_NONE;
    bb_bits = '0;
    if (!byte_i[7]) begin
      bb_unit = {8'h00, byte_i};
    end else if (byte_i[7:5] == 3'b110) begin
      bb_len  = LEN_TWO;
      bb_bits = {10'd0, byte_i[4:0]};
      bb_emit = fin_i;
    end else if (byte_i[7:4] == 4'b1110) begin
      bb_len  = LEN_THREE;
      bb_bits = {11'd0, byte_i[3:0]};
      bb_emit = fin_i;
    end else if (byte_i[7:3] == 5'b11110) begin
      bb_len  = LEN_FOUR;
      bb_bits = {12'd0, byte_i[2:0]};
      bb_emit = fin_i;
    end
  end

  // Scalar of a completing sequence and its legality.
  assign scal     = {ps_r, byte_i[5:0]};
  assign supp     = scal - SUPP_BASE;
  assign held_inc = {1'b0, held_r} + 3'd1;
  always_comb begin
    scal_bad = 1'b0;
    if (len_r == LEN_TWO && scal < MIN_LEN2)   scal_bad = 1'b1;
    if (len_r == LEN_THREE && scal < MIN_LEN3) scal_bad = 1'b1;
    if (len_r == LEN_FOUR && scal < SUPP_BASE) scal_bad = 1'b1;
    if (scal > SCALAR_MAX)                     scal_bad = 1'b1;
    if (scal >= SURR_FIRST && scal <= SURR_LAST) scal_bad = 1'b1;
  end

  // Pick replacement count, trailing words and the next sequence state.
  always_comb begin
    nrep     = 3'd0;
    ntail    = 2'd0;
    tail0    = bb_unit;
    tail1    = {LO_SURR_TAG, supp[9:0]};
    ps_nxt   = ps_r;
    len_nxt  = len_r;
    held_nxt = held_r;
    if (len_r == LEN_NONE) begin
      if (bb_emit) begin
        ntail = 2'd1;
      end else begin
        ps_nxt   = bb_bits;
        len_nxt  = bb_len;
        held_nxt = 2'd1;
      end
    end else if (byte_i[7:6] == 2'b10) begin
      if (held_inc >= len_r) begin
        ps_nxt   = '0;
        len_nxt  = LEN_NONE;
        held_nxt = '0;
        if (scal_bad) begin
          nrep = len_r;
        end else if (scal[20:16] == 5'd0) begin
          ntail = 2'd1;
          tail0 = scal[15:0];
        end else begin
          ntail = 2'd2;
          tail0 = {HI_SURR_TAG, supp[19:10]};
        end
      end else if (fin_i) begin
        ps_nxt   = '0;
        len_nxt  = LEN_NONE;
        held_nxt = '0;
        nrep     = held_inc;
      end else begin
        ps_nxt   = scal[14:0];
        held_nxt = held_inc[1:0];
      end
    end else begin
      // Flush held bytes, then restart on this byte.
      nrep = {1'b0, held_r};
      if (bb_emit) begin
        ntail    = 2'd1;
        ps_nxt   = '0;
        len_nxt  = LEN_NONE;
        held_nxt = '0;
      end else begin
        ps_nxt   = bb_bits;
        len_nxt  = bb_len;
        held_nxt = 2'd1;
      end
    end
    if (fin_i) begin
      ps_nxt   = '0;
      len_nxt  = LEN_NONE;
      held_nxt = '0;
    end
  end

  // Lay out the words: replacements first, then the trailing words.
  always_comb begin
    burst_o.count = nrep + {1'b0, ntail};
    burst_o.done  = fin_i;
    for (int i = 0; i < MAX_UNITS; i++) begin
      if (3'(i) < nrep) begin
        burst_o.units[i] = REPLACEMENT_UNIT;
      end else if (3'(i) == nrep) begin
        burst_o.units[i] = tail0;
      end else begin
        burst_o.units[i] = tail1;
      end
    end
  end

  // Advance the sequence state once per consumed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r   <= '0;
      len_r  <= LEN_NONE;
      held_r <= '0;
    end else if (advance_i) begin
      ps_r   <= ps_nxt;
      len_r  <= len_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

### src/u8u16_burst.sv
// Output buffer: holds the words of one byte and sends one per cycle while out_tready is high.
module u8u16_burst (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_i,
  input  u8u16_pkg::burst_t burst_i,
  output logic              can_load_o,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);
  import u8u16_pkg::*;

  logic [2:0]                  cnt_r;
  logic [MAX_UNITS-1:0][15:0] units_r;
  logic                        done_r;
  logic                        take;

  assign take       = (cnt_r != 3'd0) && out_tready;
  assign can_load_o = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_tready);

  // Track words left to send.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (load_i) begin
      cnt_r <= burst_i.count;
    end else if (take) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // Load a new run, or shift the next word to the head.
  always_ff @(posedge clk) begin
    if (load_i) begin
      units_r <= burst_i.units;
      done_r  <= burst_i.done;
    end else if (take) begin
      units_r <= {16'h0000, units_r[MAX_UNITS-1:1]};
    end
  end

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = units_r[0];
  assign out_tlast  = (cnt_r == 3'd1);
  assign out_tuser  = done_r;

endmodule

### src/utf8_to_utf16_transcoder_core.sv
// UTF-8 to UTF-16 transcoder, top level: input register, decoder, output buffer.
// Takes one UTF-8 byte per word (tlast marks the last byte of the text) and sends
// UTF-16 code units, one per word, with tlast on the last word a byte causes and
// tuser set on every word caused by the last byte of the text. Illegal input gives
// 0xFFFD. A byte is taken every cycle while out_tready is high and each byte gives
// at most one word; a byte that gives more (a surrogate pair or a flushed sequence,
// up to four) holds the output buffer while it sends them, and the input register
// waits behind it. Continuation bytes that only extend a pending sequence give no
// word. A byte is held in the input register, then decoded into the output buffer.
module utf8_to_utf16_transcoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_unit
  output logic        out_tlast,
  output logic        out_tuser   // [0] text_done
);
  import u8u16_pkg::*;

  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       fin_r;
  logic       can_load;
  logic       advance;
  burst_t     burst;

  assign advance   = in_valid_r && can_load;
  assign in_tready = !in_valid_r || can_load;

  // Hold the input word until the decoder consumes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      fin_r  <= in_tlast;
    end
  end

  u8u16_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance_i (advance),
    .byte_i    (byte_r),
    .fin_i     (fin_r),
    .burst_o   (burst)
  );

  u8u16_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (advance && (burst.count != 3'd0)),
    .burst_i    (burst),
    .can_load_o (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### src/u8u16_chk.sv
// Port-level checker for the transcoder, bound to the top level.
`include "utf8_to_utf16_transcoder_core_macros.svh"

module u8u16_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);
  import u8u16_pkg::*;

  // Hold a stalled word.
  `U8U16_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled word changed")

  // A run continues right after a non-last word, with the same text_done.
  `U8U16_ASSERT_NEXT(a_run_cont, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tuser == $past(out_tuser)), "run broken or text_done changed")

  // Only replacements and high surrogates precede the last word of a run.
  `U8U16_ASSERT_NOW(a_mid_kind, out_tvalid && !out_tlast, (out_tdata == REPLACEMENT_UNIT) || (out_tdata[15:10] == HI_SURR_TAG), "unexpected word inside run")

  // A low surrogate follows every high surrogate.
  `U8U16_ASSERT_NEXT(a_pair, out_tvalid && out_tready && (out_tdata[15:10] == HI_SURR_TAG), out_tvalid && (out_tdata[15:10] == LO_SURR_TAG), "high surrogate without low")

endmodule

bind utf8_to_utf16_transcoder_core u8u16_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

### verif/utf8_to_utf16_transcoder_core_tb.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder core.
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_core_tb;
  import u8u16_pkg::*;

  localparam int RANDOM_BYTES = 460;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 300;
  localparam int TAIL_CYCLES  = 8;
  localparam int MAX_REPORTS  = 10;

  // Decoder of the byte stream with its own copy of the sequence state, and
  // the queue of code units it expects the block to send.
  class utf16_scoreboard;
    typedef struct {
      logic [15:0] unit;
      logic        last;
      logic        done;
    } utf16_word_t;

    utf16_word_t expected_words[$];
    utf16_word_t run_words[$];
    logic [20:0] partial;
    logic [2:0]  seq_len;
    logic [1:0]  held_cnt;
    int          errors;

    function new();
      partial  = '0;
      seq_len  = LEN_NONE;
      held_cnt = '0;
      errors   = 0;
    endfunction

    function void clear_seq();
      partial  = '0;
      seq_len  = LEN_NONE;
      held_cnt = '0;
    endfunction

    function void add_unit(logic [15:0] unit, logic fin);
      utf16_word_t w;
      if (run_words.size() < MAX_UNITS) begin
        w.unit = unit;
        w.last = 1'b0;
        w.done = fin;
        run_words.insert(run_words.size(), w);
      end
    endfunction

    function void add_replacements(int count, logic fin);
      for (int k = 0; k < count; k++) add_unit(REPLACEMENT_UNIT, fin);
    endfunction

    // Start a new sequence or emit a single-byte result.
    function void start_byte(logic [7:0] b, logic fin);
      logic [2:0]  len;
      logic [20:0] bits;
      if (b[7] == 1'b0) begin
        add_unit({8'h00, b}, fin);
        return;
      end
      if (b[7:5] == 3'b110) begin
        len  = LEN_TWO;
        bits = {16'h0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        len  = LEN_THREE;
        bits = {17'h0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        len  = LEN_FOUR;
        bits = {18'h0, b[2:0]};
      end else begin
        add_unit(REPLACEMENT_UNIT, fin);
        return;
      end
      if (fin) begin
        add_unit(REPLACEMENT_UNIT, fin);
        return;
      end
      partial  = bits;
      seq_len  = len;
      held_cnt = 2'd1;
    endfunction

    function bit scalar_illegal(logic [20:0] s, logic [2:0] len);
      if (len == LEN_TWO && s < MIN_LEN2) return 1'b1;
      if (len == LEN_THREE && s < MIN_LEN3) return 1'b1;
      if (len == LEN_FOUR && s < SUPP_BASE) return 1'b1;
      if (s > SCALAR_MAX) return 1'b1;
      return (s >= SURR_FIRST && s <= SURR_LAST);
    endfunction

    // Note an accepted text byte and queue the words it causes.
    function void note_byte(logic [7:0] b, logic fin);
      logic [20:0] s;
      logic [20:0] v;
      logic [2:0]  len;
      int          held;
      run_words.delete();
      if (seq_len == LEN_NONE) begin
        start_byte(b, fin);
      end else if (b[7:6] == 2'b10) begin
        s    = {partial[14:0], b[5:0]};
        held = int'(held_cnt) + 1;
        if (held >= int'(seq_len)) begin
          len = seq_len;
          clear_seq();
          if (scalar_illegal(s, len)) begin
            add_replacements(int'(len), fin);
          end else if (s < SUPP_BASE) begin
            add_unit(s[15:0], fin);
          end else begin
            v = s - SUPP_BASE;
            add_unit({HI_SURR_TAG, v[19:10]}, fin);
            add_unit({LO_SURR_TAG, v[9:0]}, fin);
          end
        end else if (fin) begin
          clear_seq();
          add_replacements(held, fin);
        end else begin
          partial  = s;
          held_cnt = held[1:0];
        end
      end else begin
        held = int'(held_cnt);
        clear_seq();
        add_replacements(held, fin);
        start_byte(b, fin);
      end
      if (fin) clear_seq();
      if (run_words.size() > 0) run_words[run_words.size()-1].last = 1'b1;
      foreach (run_words[k]) expected_words.insert(expected_words.size(), run_words[k]);
    endfunction

    // Compare a received word against the oldest expectation.
    function void check_word(logic [15:0] unit, logic last, logic done);
      utf16_word_t w;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected word: unit %h last %b done %b", unit, last, done);
        return;
      end
      w = expected_words.pop_front();
      if (w.unit !== unit || w.last !== last || w.done !== done) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: expected unit %h last %b done %b, got unit %h last %b done %b",
                   w.unit, w.last, w.done, unit, last, done);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  utf16_scoreboard sb = new();

  logic [7:0] text_bytes[$];
  logic       final_flags[$];

  utf8_to_utf16_transcoder_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_byte(logic [7:0] b, logic fin);
    text_bytes.insert(text_bytes.size(), b);
    final_flags.insert(final_flags.size(), fin);
  endfunction

  // Encode s in the len-byte form and queue the first keep bytes of it.
  function automatic void push_encoded(logic [20:0] s, int len, int keep);
    logic [7:0] seq[4];
    case (len)
      1: seq[0] = {1'b0, s[6:0]};
      2: begin
        seq[0] = {3'b110, s[10:6]};
        seq[1] = {2'b10, s[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, s[15:12]};
        seq[1] = {2'b10, s[11:6]};
        seq[2] = {2'b10, s[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, s[20:18]};
        seq[1] = {2'b10, s[17:12]};
        seq[2] = {2'b10, s[11:6]};
        seq[3] = {2'b10, s[5:0]};
      end
    endcase
    for (int k = 0; k < keep; k++) push_byte(seq[k], $urandom_range(0, 49) == 0);
  endfunction

  function automatic logic [20:0] legal_scalar(int len);
    logic [20:0] s;
    case (len)
      1: s = 21'($urandom_range(0, 'h7F));
      2: s = 21'($urandom_range('h80, 'h7FF));
      3: begin
        s = 21'($urandom_range('h800, 'hFFFF));
        // move surrogates up out of the surrogate range
        if (s >= SURR_FIRST && s <= SURR_LAST) s = s ^ 21'h2000;
      end
      default: s = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return s;
  endfunction

  function automatic void build_stimulus();
    int          r;
    int          len;
    logic [20:0] s;
    // directed: extremes and each kind of error (overlong, surrogate, too large, cut short, stray byte)
    push_byte(8'h7F, 1'b0);
    push_byte(8'hC2, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hF4, 1'b0); push_byte(8'h8F, 1'b0);
    push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hED, 1'b0); push_byte(8'hA0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hF4, 1'b0); push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hF0, 1'b0); push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h41, 1'b0);
    push_byte(8'hC3, 1'b1);
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);
    r = text_bytes.size() + RANDOM_BYTES;
    while (text_bytes.size() < r) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
          len = $urandom_range(1, 4);
          push_encoded(legal_scalar(len), len, len);
        end
        13, 14: begin
          // overlong, surrogate or beyond the code space
          case ($urandom_range(0, 2))
            0: begin
              len = $urandom_range(2, 4);
              s = 21'((len == 2) ? $urandom_range(0, 'h7F) :
                      (len == 3) ? $urandom_range(0, 'h7FF) : $urandom_range(0, 'hFFFF));
            end
            1: begin
              len = 3;
              s = 21'($urandom_range(SURR_FIRST, SURR_LAST));
            end
            default: begin
              len = 4;
              s = 21'($urandom_range('h110000, 'h1FFFFF));
            end
          endcase
          push_encoded(s, len, len);
        end
        15, 16: begin
          // sequence broken off by whatever comes next
          len = $urandom_range(2, 4);
          push_encoded(legal_scalar(len), len, $urandom_range(1, len - 1));
        end
        default: push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
      endcase
      if ($urandom_range(0, 9) == 0) final_flags[final_flags.size()-1] = 1'b1;
    end
  endfunction

  // Offer the queued bytes in bursts with random gaps.
  task automatic drive_bytes();
    int burst_left;
    int gap;
    burst_left = 0;
    for (int k = 0; k < text_bytes.size(); k++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          in_tvalid = 1'b0;
          gap = $urandom_range(1, 8);
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 48);
      end
      in_tvalid = 1'b1;
      in_tdata  = text_bytes[k];
      in_tlast  = final_flags[k];
      do @(posedge clk); while (!in_tready);
      @(negedge clk);
      burst_left--;
    end
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
  endtask

  // Stall the output in changing patterns, with one long hold-off.
  initial begin : receiver
    int cyc;
    int mode;
    int hold_left;
    out_tready = 1'b0;
    cyc        = 0;
    mode       = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == HOLD_AT) hold_left = HOLD_LEN;
      if (cyc % 97 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        case (mode)
          0:       out_tready = 1'b1;
          1:       out_tready = 1'($urandom_range(0, 1));
          2:       out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = ((cyc % 7) < 5);
        endcase
      end
    end
  end

  // Track each word in both directions.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast, out_tuser);
    end
  end

  // End the run if no word moves for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("** utf8_to_utf16_transcoder_core: FAILED **");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    build_stimulus();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    drive_bytes();
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0d expected words never arrived", sb.pending());
    end
    if (sb.errors == 0) begin
      $display("** utf8_to_utf16_transcoder_core: PASSED **");
    end else begin
      $display("** utf8_to_utf16_transcoder_core: FAILED **");
    end
    $finish;
  end

endmodule

### utf8_to_utf16_transcoder_core.f
+incdir+src
src/u8u16_pkg.sv
src/u8u16_decode.sv
src/u8u16_burst.sv
src/utf8_to_utf16_transcoder_core.sv
src/u8u16_chk.sv
verif/utf8_to_utf16_transcoder_core_tb.sv
